FILE: rtl/core/nlsc_pkg.sv
// package: types, codes and character tables of the nested list syntax checker
`timescale 1ns / 1ps

package nlsc_pkg;

   localparam int DEPTH_BITS_DEFAULT = 8;
   localparam int CHAR_WIDTH = 8;

   typedef enum logic [2:0] {
      KIND_NONE   = 3'd0,
      KIND_PAREN  = 3'd1,
      KIND_SQUARE = 3'd2,
      KIND_CURLY  = 3'd3,
      KIND_ANGLE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      SEP_OPEN  = 2'd0,
      SEP_COMMA = 2'd1,
      SEP_CLOSE = 2'd2
   } sep_type;

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_OPEN  = 2'd1,
      CLS_COMMA = 2'd2,
      CLS_CLOSE = 2'd3
   } cls_type;

   localparam logic [CHAR_WIDTH-1:0] CHAR_COMMA = 8'h2c;

   typedef struct packed {
      logic     is_open;
      logic     is_close;
      logic     is_comma;
      logic     is_entry;
      kind_type start_kind;
   } char_class_type;

   function automatic logic [CHAR_WIDTH-1:0] open_of(input kind_type kind);
      logic [CHAR_WIDTH-1:0] c;
      case (kind)
         KIND_PAREN:  c = 8'h28;
         KIND_SQUARE: c = 8'h5b;
         KIND_CURLY:  c = 8'h7b;
         KIND_ANGLE:  c = 8'h3c;
         default:     c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic [CHAR_WIDTH-1:0] close_of(input kind_type kind);
      logic [CHAR_WIDTH-1:0] c;
      case (kind)
         KIND_PAREN:  c = 8'h29;
         KIND_SQUARE: c = 8'h5d;
         KIND_CURLY:  c = 8'h7d;
         KIND_ANGLE:  c = 8'h3e;
         default:     c = 8'h00;
      endcase
      return c;
   endfunction

   // letters, digits and _.-!@#$%^&*+=?
   function automatic logic is_entry_char(input logic [CHAR_WIDTH-1:0] c);
      return c inside {[8'h61:8'h7a], [8'h41:8'h5a], [8'h30:8'h39],
                       8'h5f, 8'h2e, 8'h2d, 8'h21, 8'h40, 8'h23, 8'h24,
                       8'h25, 8'h5e, 8'h26, 8'h2a, 8'h2b, 8'h3d, 8'h3f};
   endfunction

endpackage

FILE: rtl/core/nlsc_classify.sv
// character classifier: brackets of the chosen kind, comma, entry characters, start kind of any opening bracket
`timescale 1ns / 1ps

module nlsc_classify
   import nlsc_pkg::*;
(
   input  logic [CHAR_WIDTH-1:0] char_code,
   input  kind_type              kind,
   output char_class_type        char_class
);

   logic has_kind;

   assign has_kind = (kind != KIND_NONE);

   always_comb begin
      char_class.is_open  = has_kind && (char_code == open_of(kind));
      char_class.is_close = has_kind && (char_code == close_of(kind));
      char_class.is_comma = (char_code == CHAR_COMMA);
      char_class.is_entry = is_entry_char(char_code);
      case (char_code)
         open_of(KIND_PAREN):  char_class.start_kind = KIND_PAREN;
         open_of(KIND_SQUARE): char_class.start_kind = KIND_SQUARE;
         open_of(KIND_CURLY):  char_class.start_kind = KIND_CURLY;
         open_of(KIND_ANGLE):  char_class.start_kind = KIND_ANGLE;
         default:              char_class.start_kind = KIND_NONE;
      endcase
   end

endmodule

FILE: rtl/core/nlsc_tracker.sv
// syntax state: separator rules, depth counter and end-of-string verdict
`timescale 1ns / 1ps

module nlsc_tracker
   import nlsc_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [CHAR_WIDTH-1:0] char_code,
   input  logic                  is_last,
   output logic                  list_ok,
   output logic                  depth_overflow
);

   localparam logic [DEPTH_BITS-1:0] MAX_DEPTH = {DEPTH_BITS{1'b1}};

   kind_type              kind_ff, kind_in;
   logic [1:0]            seen_ff, seen_in;
   sep_type               sep_ff, sep_in;
   logic                  gap_ff, gap_in;
   cls_type               prev_ff, prev_in;
   logic [DEPTH_BITS-1:0] depth_ff, depth_in;
   logic                  failed_ff, failed_in;
   logic                  ovf_ff, ovf_in;
   cls_type               cls;
   char_class_type        cc;

   nlsc_classify u_classify (
      .char_code  (char_code),
      .kind       (kind_ff),
      .char_class (cc)
   );

   always_comb begin
      kind_in   = kind_ff;
      sep_in    = sep_ff;
      gap_in    = gap_ff;
      depth_in  = depth_ff;
      failed_in = failed_ff;
      ovf_in    = ovf_ff;
      cls       = CLS_OTHER;
      if (seen_ff == 2'd0) begin
         kind_in = cc.start_kind;
         if (cc.start_kind == KIND_NONE) begin
            failed_in = 1'b1;
         end else begin
            cls      = CLS_OPEN;
            depth_in = DEPTH_BITS'(1);
         end
         sep_in = SEP_OPEN;
         gap_in = 1'b1;
      end else if (cc.is_open || cc.is_close || cc.is_comma) begin
         if ((cc.is_comma || cc.is_close) && gap_ff &&
             (sep_ff == SEP_OPEN || sep_ff == SEP_COMMA)) begin
            failed_in = 1'b1;
         end
         if (cc.is_open && prev_ff != CLS_COMMA && prev_ff != CLS_OPEN) begin
            failed_in = 1'b1;
         end
         if (cc.is_open) begin
            if (depth_ff == MAX_DEPTH) begin
               ovf_in = 1'b1;
            end else begin
               depth_in = depth_ff + DEPTH_BITS'(1);
            end
            cls    = CLS_OPEN;
            sep_in = SEP_OPEN;
         end else if (cc.is_close) begin
            if (depth_ff == '0) begin
               failed_in = 1'b1;
            end else begin
               depth_in = depth_ff - DEPTH_BITS'(1);
            end
            cls    = CLS_CLOSE;
            sep_in = SEP_CLOSE;
         end else begin
            cls    = CLS_COMMA;
            sep_in = SEP_COMMA;
         end
         gap_in = 1'b1;
      end else begin
         if (!cc.is_entry) begin
            failed_in = 1'b1;
         end
         gap_in = 1'b0;
      end
      prev_in = cls;
      seen_in = (seen_ff == 2'd2) ? seen_ff : seen_ff + 2'd1;

      list_ok = !failed_in && !ovf_in && (seen_in == 2'd2) &&
                (cls == CLS_CLOSE) && (depth_in == '0);
      depth_overflow = ovf_in;

      // string done, start over
      if (is_last) begin
         kind_in   = KIND_NONE;
         seen_in   = 2'd0;
         sep_in    = SEP_OPEN;
         gap_in    = 1'b1;
         prev_in   = CLS_OTHER;
         depth_in  = '0;
         failed_in = 1'b0;
         ovf_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff   <= KIND_NONE;
         seen_ff   <= 2'd0;
         sep_ff    <= SEP_OPEN;
         gap_ff    <= 1'b1;
         prev_ff   <= CLS_OTHER;
         depth_ff  <= '0;
         failed_ff <= 1'b0;
         ovf_ff    <= 1'b0;
      end else if (step) begin
         kind_ff   <= kind_in;
         seen_ff   <= seen_in;
         sep_ff    <= sep_in;
         gap_ff    <= gap_in;
         prev_ff   <= prev_in;
         depth_ff  <= depth_in;
         failed_ff <= failed_in;
         ovf_ff    <= ovf_in;
      end
   end

endmodule

FILE: rtl/core/nested_list_syntax_checker_unit.sv
// top level: input register, syntax tracker and result register
//
//  channel | direction | signals                                   | moves
//  req     | in        | req_valid req_ready req_char_code req_is_last | one character
//  rsp     | out       | rsp_valid rsp_ready rsp_list_ok rsp_depth_overflow | verdict per string
//
// one character per cycle while no last character is held back by a full result register;
// a character waits in the input register, and its verdict, if it is the last one,
// is loaded into the result register when that character steps the tracker
// synchronous active-high reset clears the pipeline valids and the syntax state
// a held response stalls only a last character; others keep flowing
`timescale 1ns / 1ps

module nested_list_syntax_checker_unit
   import nlsc_pkg::*;
#(
   parameter int DEPTH_BITS = DEPTH_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CHAR_WIDTH-1:0] req_char_code,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_list_ok,
   output logic                  rsp_depth_overflow
);

   logic                  in_valid_ff, in_valid_in;
   logic [CHAR_WIDTH-1:0] in_char_ff;
   logic                  in_last_ff;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_ok_ff;
   logic                  out_ovf_ff;
   logic                  out_free;
   logic                  step;
   logic                  ok;
   logic                  ovf;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign step      = in_valid_ff && (!in_last_ff || out_free);
   assign req_ready = !in_valid_ff || step;

   assign in_valid_in  = req_valid || (in_valid_ff && !step);
   assign out_valid_in = (step && in_last_ff) || (out_valid_ff && !rsp_ready);

   nlsc_tracker #(
      .DEPTH_BITS (DEPTH_BITS)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .step           (step),
      .char_code      (in_char_ff),
      .is_last        (in_last_ff),
      .list_ok        (ok),
      .depth_overflow (ovf)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= in_valid_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff <= req_char_code;
         in_last_ff <= req_is_last;
      end
      if (step && in_last_ff) begin
         out_ok_ff  <= ok;
         out_ovf_ff <= ovf;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_list_ok        = out_ok_ff;
   assign rsp_depth_overflow = out_ovf_ff;

endmodule
